// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define SCT_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("coherence check failed");

// Next-cycle implication, disabled while reset is held
`define SCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("coherence check failed");

`endif

// ===== design/sct_pkg.sv =====
// Types and constants for the snoop coherence transition block
`timescale 1ns / 1ps

package sct_pkg;

	localparam int unsigned InDataW  = 8;
	localparam int unsigned InUserW  = 2;
	localparam int unsigned OutDataW = 8;
	localparam int unsigned CfgAddrW = 1;
	localparam int unsigned CfgDataW = 2;

	typedef enum logic [1:0] {
		PROTO_MSI   = 2'd0,
		PROTO_MESI  = 2'd1,
		PROTO_MOSI  = 2'd2,
		PROTO_MOESI = 2'd3
	} proto_t;

	typedef enum logic [CfgAddrW-1:0] {
		REG_PROTOCOL_KIND = 1'd0,
		REG_USE_UPGRADES  = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_REQUEST  = 2'd0,
		ACT_RESPONSE = 2'd1,
		ACT_SNOOP    = 2'd2,
		ACT_UNUSED   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CMD_READ    = 3'd0,
		CMD_WRITE   = 3'd1,
		CMD_READEX  = 3'd2,
		CMD_UPGRADE = 3'd3,
		CMD_SWPF    = 3'd4,
		CMD_HWPF    = 3'd5,
		CMD_INV     = 3'd6,
		CMD_WRINV   = 3'd7
	} cmd_t;

	// line state encoding; codes 5 to 7 are not states
	localparam logic [2:0] ST_I = 3'd0;
	localparam logic [2:0] ST_S = 3'd1;
	localparam logic [2:0] ST_E = 3'd2;
	localparam logic [2:0] ST_O = 3'd3;
	localparam logic [2:0] ST_M = 3'd4;

	localparam logic [1:0] BUS_READ    = 2'd0;
	localparam logic [1:0] BUS_READEX  = 2'd1;
	localparam logic [1:0] BUS_UPGRADE = 2'd2;

	typedef struct packed {
		logic       error;
		logic       assert_shared;
		logic       supply_data;
		logic [2:0] next_state;
		logic [1:0] bus_command;
	} result_t;

	typedef struct packed {
		logic       peer_shared;
		logic       has_block;
		logic [2:0] line_state;
		cmd_t       command;
	} item_t;

endpackage

// ===== design/snoop_coherence_transition.sv =====
// Snoop coherence transition block: input register, decode, result register
// Usage:
//   Slave stream s_axis_* carries one item per handshake: tuser holds the
//   action (request, response or snoop), tdata the command, line state,
//   has_block and peer_shared flags. Master stream m_axis_* returns one
//   result per item, in order: bus command, next state, supply_data,
//   assert_shared and error.
//   The item is registered in the input register after its input handshake, and
//   the decode loads the result register from it, which raises m_axis_tvalid.
//   Throughput is one item per cycle; both stages move together, so a full
//   pipe keeps accepting as long as the result side takes an item each cycle.
//   When the receiver stalls the result is held, the input stage fills, and
//   s_axis_tready drops only once both stages hold an item.
//   The configuration port (cfg_we, cfg_addr, cfg_wdata) selects MSI, MESI,
//   MOSI or MOESI and upgrade use; write it only while no item is in flight.
//   Reset empties both stages and sets MSI with upgrades enabled.
`timescale 1ns / 1ps

module snoop_coherence_transition (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sct_pkg::CfgAddrW-1:0]  cfg_addr,
	input  logic [sct_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// command[2:0], line_state[5:3], has_block[6], peer_shared[7]
	input  logic [sct_pkg::InDataW-1:0]   s_axis_tdata,
	// action[1:0]
	input  logic [sct_pkg::InUserW-1:0]   s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// bus_command[1:0], next_state[4:2], supply_data[5], assert_shared[6], error[7]
	output logic [sct_pkg::OutDataW-1:0]  m_axis_tdata
);
	import sct_pkg::*;

	proto_t  protocol_kind_q;
	logic    use_upgrades_q;

	logic    valid_s1;
	action_t action_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;

	logic    ready_s1;
	logic    ready_s2;
	result_t result_d;

	logic    has_excl;
	logic    has_owned;
	logic    upg_on;
	logic    write_hit;
	logic    st_exists;
	logic [2:0] st;
	cmd_t    cmd;

	assign ready_s2      = !valid_s2 || m_axis_tready;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_kind_q <= PROTO_MSI;
			use_upgrades_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_PROTOCOL_KIND: protocol_kind_q <= proto_t'(cfg_wdata[1:0]);
				REG_USE_UPGRADES:  use_upgrades_q  <= cfg_wdata[0];
				default:           ;
			endcase
		end
	end

	// advance both stages together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_axis_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			action_s1 <= action_t'(s_axis_tuser);
			item_s1   <= item_t'(s_axis_tdata);
		end
		if (ready_s2 && valid_s1) result_s2 <= result_d;
	end

	assign has_excl  = protocol_kind_q[0];
	assign has_owned = protocol_kind_q[1];
	assign upg_on    = use_upgrades_q || has_owned;
	assign st        = item_s1.line_state;
	assign cmd       = item_s1.command;
	assign write_hit = (st == ST_S) || (st == ST_O && has_owned);

	always_comb begin
		case (st)
			ST_I, ST_S, ST_M: st_exists = 1'b1;
			ST_E:             st_exists = has_excl;
			ST_O:             st_exists = has_owned;
			default:          st_exists = 1'b0;
		endcase
	end

	always_comb begin
		// default is the undefined transition: hold state, flag error
		result_d             = '0;
		result_d.next_state  = st;
		result_d.error       = 1'b1;
		unique case (action_s1)
			ACT_REQUEST: begin
				if (st == ST_I) begin
					if (cmd inside {CMD_READ, CMD_SWPF, CMD_HWPF}) begin
						result_d.bus_command = BUS_READ;
						result_d.error       = 1'b0;
					end else if (cmd == CMD_WRITE) begin
						result_d.bus_command = BUS_READEX;
						result_d.error       = 1'b0;
					end
				end else if (write_hit && cmd == CMD_WRITE) begin
					result_d.bus_command = upg_on ? BUS_UPGRADE : BUS_READEX;
					result_d.error       = 1'b0;
				end
			end
			ACT_RESPONSE: begin
				if (st == ST_I && cmd == CMD_READ) begin
					result_d.next_state =
						(has_excl && !item_s1.peer_shared) ? ST_E : ST_S;
					result_d.error      = 1'b0;
				end else if (st == ST_I && cmd == CMD_READEX) begin
					result_d.next_state = ST_M;
					result_d.error      = 1'b0;
				end else if (write_hit &&
						cmd == (upg_on ? CMD_UPGRADE : CMD_READEX)) begin
					result_d.next_state = ST_M;
					result_d.error      = 1'b0;
				end
			end
			ACT_SNOOP: begin
				if (!item_s1.has_block) begin
					result_d.next_state = ST_I;
					result_d.error      = 1'b0;
				end else if (st_exists) begin
					case (cmd)
						CMD_INV, CMD_WRINV: begin
							result_d.next_state = ST_I;
							result_d.error      = 1'b0;
						end
						CMD_READ: begin
							result_d.error = 1'b0;
							case (st)
								ST_S: result_d.assert_shared = (protocol_kind_q != PROTO_MSI);
								ST_E: begin
									result_d.next_state    = ST_S;
									result_d.assert_shared = 1'b1;
								end
								ST_M: begin
									result_d.next_state    = has_owned ? ST_O : ST_S;
									result_d.supply_data   = 1'b1;
									result_d.assert_shared = 1'b1;
								end
								ST_O: begin
									result_d.supply_data   = 1'b1;
									result_d.assert_shared = 1'b1;
								end
								default: ;
							endcase
						end
						CMD_READEX: begin
							result_d.next_state  = ST_I;
							result_d.supply_data = (st == ST_O) || (st == ST_M);
							result_d.error       = 1'b0;
						end
						CMD_UPGRADE: begin
							if (upg_on && (st == ST_I || st == ST_S || st == ST_O)) begin
								result_d.next_state = ST_I;
								result_d.error      = 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== design/sct_checker.sv =====
// Port-level checks for the snoop coherence transition block, with bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sct_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [sct_pkg::OutDataW-1:0]  m_axis_tdata
);
	import sct_pkg::*;

	result_t res;
	assign res = result_t'(m_axis_tdata);

	`SCT_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`SCT_ASSERT(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`SCT_ASSERT(a_error_clean, clk, arst_n, m_axis_tvalid && res.error, res.bus_command == BUS_READ && !res.supply_data && !res.assert_shared)
	`SCT_ASSERT(a_bus_code, clk, arst_n, m_axis_tvalid, res.bus_command == BUS_READ || res.bus_command == BUS_READEX || res.bus_command == BUS_UPGRADE)
	`SCT_ASSERT(a_supply_snoop_only, clk, arst_n, m_axis_tvalid && res.supply_data, res.bus_command == BUS_READ && !res.error)

endmodule

bind snoop_coherence_transition sct_checker u_sct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
